FILE: hdl/wmu_pkg.sv
// Shared types, codes and constants for the window margin update block.
package wmu_pkg;

    localparam int FRAC_BITS_DEF = 24;

    // Stream payload widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_DATA_W = 160;
    localparam int M_DATA_W = 104;

    // Divider denominator holds norm squared
    localparam int DEN_W = 62;
    localparam int Q_W   = 32;

    localparam logic [Q_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] NEG_MIN = 32'h8000_0000;

    localparam logic OP_ACC   = 1'b0;
    localparam logic OP_SCALE = 1'b1;

    localparam logic KIND_DECISION = 1'b0;
    localparam logic KIND_SCALED   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DECIDE,
        ST_SCORE_START,
        ST_SCORE_RUN,
        ST_STEP_RUN,
        ST_EMIT
    } wmu_state_t;

    typedef struct packed {
        logic load_in;
        logic mul_en;
        logic acc_en;
        logic decide_en;
        logic div_start;
        logic div_sel_step;
        logic score_ld;
        logic step_ld;
        logic out_ld;
    } wmu_cmd_t;

    typedef struct packed {
        logic op;
        logic last;
        logic dec_upd;
        logic div_busy;
        logic div_done;
        logic out_free;
    } wmu_status_t;

endpackage

FILE: hdl/wmu_div.sv
// Bit-serial restoring divider with a saturated 32-bit quotient.
module wmu_div #(
    parameter int NUM_W = 64 + 2 * wmu_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_W-1:0]           num,
    input  logic [wmu_pkg::DEN_W-1:0]  den,
    output logic                       busy,
    output logic                       done,
    output logic [wmu_pkg::Q_W-1:0]    quot
);
    import wmu_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   q_reg;
    logic             ovf_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;
    logic [DEN_W-1:0] rem_new;

    // Bring down one numerator bit per cycle; the remainder stays below den.
    // A zero divisor sets every quotient bit and so saturates by itself.
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign rem_new = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_new;
            q_reg   <= {q_reg[Q_W-2:0], ge};
            // Any bit shifted out of the top means the quotient is too large
            ovf_reg <= ovf_reg | q_reg[Q_W-1];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = (ovf_reg || q_reg[Q_W-1]) ? POS_MAX : q_reg;

`ifndef SYNTHESIS
    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("divider did not start");
`endif

endmodule

FILE: hdl/wmu_dp.sv
// Datapath: input stage, shared multiplier, accumulator, decision and result registers.
module wmu_dp #(
    parameter int FRAC_BITS = wmu_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [wmu_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  wmu_pkg::wmu_cmd_t             cmd,
    output wmu_pkg::wmu_status_t          status,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [wmu_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);
    import wmu_pkg::*;

    localparam int NUM_W = 64 + 2 * FRAC_BITS;

    // Input stage
    logic        op_reg;
    logic        last_reg;
    logic [31:0] alpha_reg;
    logic [31:0] ker_reg;
    logic [31:0] kpr_reg;
    logic [31:0] sigma_reg;
    logic [30:0] norm_reg;

    // Multiply stage
    logic [63:0] prod_reg;
    logic        neg_reg;
    logic [DEN_W-1:0] normsq_reg;

    // State
    logic [63:0] acc_reg;
    logic [31:0] stored_step_reg;
    logic        stored_dir_reg;
    logic        stored_upd_reg;
    logic [63:0] diff_reg;

    // Pending result
    logic        res_kind_reg;
    logic        res_upd_reg;
    logic        res_dir_reg;
    logic [31:0] res_step_reg;
    logic [31:0] res_score_reg;
    logic [31:0] res_scaled_reg;

    // Output register
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic        out_upd_reg;
    logic        out_dir_reg;
    logic [31:0] out_step_reg;
    logic [31:0] out_score_reg;
    logic [31:0] out_scaled_reg;

    logic [32:0] kdiff;
    logic [32:0] kdiff_abs;
    logic        kdiff_neg;
    logic        kdiff_pos;
    logic [31:0] alpha_mag;
    logic [31:0] a_mag;
    logic [31:0] d_mag;
    logic        a_neg;
    logic        d_neg;
    logic [63:0] prod_full;
    logic [DEN_W-1:0] normsq_full;

    logic [63:0] shifted;
    logic [63:0] term;
    logic [64:0] sum;
    logic [63:0] acc_sat;
    logic [31:0] scaled_sat;

    logic [65:0] sj_x;
    logic [65:0] sg_x;
    logic [65:0] d1;
    logic [65:0] d2;
    logic        c1;
    logic        c2;
    logic        dec_upd;
    logic        dec_dir;
    logic [63:0] dec_diff;

    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_busy;
    logic             div_done;
    logic [Q_W-1:0]   div_q;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= s_tuser;
            last_reg  <= s_tlast;
            alpha_reg <= s_tdata[31:0];
            ker_reg   <= s_tdata[63:32];
            kpr_reg   <= s_tdata[95:64];
            sigma_reg <= s_tdata[127:96];
            norm_reg  <= s_tdata[158:128];
        end
    end

    // Sign and magnitude of both factors; the product is formed unsigned
    assign kdiff     = {ker_reg[31], ker_reg} - {kpr_reg[31], kpr_reg};
    assign kdiff_neg = kdiff[32];
    assign kdiff_pos = !kdiff[32] && (kdiff != '0);
    assign kdiff_abs = kdiff_neg ? (33'd0 - kdiff) : kdiff;
    assign d_mag     = kdiff_abs[31:0];
    assign alpha_mag = alpha_reg[31] ? (32'd0 - alpha_reg) : alpha_reg;
    assign a_mag     = (op_reg == OP_SCALE) ? stored_step_reg : alpha_mag;
    assign a_neg     = (op_reg == OP_SCALE) ? 1'b0 : alpha_reg[31];
    // Direction one flips the difference to kprime minus kernel
    assign d_neg     = (op_reg == OP_SCALE && stored_dir_reg) ? kdiff_pos : kdiff_neg;
    assign prod_full   = a_mag * d_mag;
    assign normsq_full = norm_reg * norm_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg   <= prod_full;
            neg_reg    <= a_neg ^ d_neg;
            normsq_reg <= normsq_full;
        end
    end

    // Truncate toward zero: shift the magnitude, then apply the sign
    assign shifted = prod_reg >> FRAC_BITS;
    assign term    = neg_reg ? (64'd0 - shifted) : shifted;
    assign sum     = {acc_reg[63], acc_reg} + {term[63], term};
    assign acc_sat = (sum[64] != sum[63])
                   ? (sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                   : sum[63:0];
    assign scaled_sat = (term[63:31] == {33{term[63]}}) ? term[31:0]
                      : (term[63] ? NEG_MIN : POS_MAX);

    // Margin checks: sj > sigma, else sj < -sigma
    assign sj_x     = {{2{acc_reg[63]}}, acc_reg};
    assign sg_x     = {{34{sigma_reg[31]}}, sigma_reg};
    assign d1       = sj_x - sg_x;
    assign d2       = 66'd0 - sj_x - sg_x;
    assign c1       = !d1[65] && (d1 != '0);
    assign c2       = !d2[65] && (d2 != '0);
    assign dec_upd  = c1 || c2;
    assign dec_dir  = !c1 && c2;
    assign dec_diff = c1 ? d1[63:0] : d2[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= '0;
            stored_step_reg <= '0;
            stored_dir_reg  <= 1'b0;
            stored_upd_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.acc_en && op_reg == OP_ACC)
            begin
                acc_reg <= acc_sat;
            end
            else if (cmd.decide_en)
            begin
                acc_reg <= '0;
            end

            if (cmd.decide_en)
            begin
                stored_upd_reg  <= dec_upd;
                stored_dir_reg  <= dec_dir;
                stored_step_reg <= '0;
            end
            else if (cmd.step_ld)
            begin
                stored_step_reg <= div_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en && op_reg == OP_SCALE)
        begin
            res_kind_reg   <= KIND_SCALED;
            res_upd_reg    <= stored_upd_reg;
            res_dir_reg    <= stored_dir_reg;
            res_step_reg   <= stored_step_reg;
            res_score_reg  <= '0;
            res_scaled_reg <= scaled_sat;
        end
        else if (cmd.decide_en)
        begin
            res_kind_reg   <= KIND_DECISION;
            res_upd_reg    <= dec_upd;
            res_dir_reg    <= dec_dir;
            res_step_reg   <= '0;
            res_score_reg  <= '0;
            res_scaled_reg <= '0;
            diff_reg       <= dec_diff;
        end
        else if (cmd.score_ld)
        begin
            res_score_reg <= div_q;
        end
        else if (cmd.step_ld)
        begin
            res_step_reg <= div_q;
        end
    end

    // Score divides by norm with FRAC_BITS of scaling, step by norm squared with twice that
    assign div_num = cmd.div_sel_step
                   ? {diff_reg, {(2 * FRAC_BITS){1'b0}}}
                   : {{FRAC_BITS{1'b0}}, diff_reg, {FRAC_BITS{1'b0}}};
    assign div_den = cmd.div_sel_step ? normsq_reg : {31'd0, norm_reg};

    wmu_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_kind_reg   <= res_kind_reg;
            out_upd_reg    <= res_upd_reg;
            out_dir_reg    <= res_dir_reg;
            out_step_reg   <= res_step_reg;
            out_score_reg  <= res_score_reg;
            out_scaled_reg <= res_scaled_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_scaled_reg, out_score_reg, out_step_reg,
                       out_dir_reg, out_upd_reg};

    assign status.op       = op_reg;
    assign status.last     = last_reg;
    assign status.dec_upd  = dec_upd;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_tready;

`ifndef SYNTHESIS
    a_no_upd_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide_en && !dec_upd) |=> (stored_step_reg == '0 && !stored_dir_reg))
        else $error("stored step not cleared without update");
`endif

endmodule

FILE: hdl/wmu_ctrl.sv
// Controller state machine sequencing input, multiply, accumulate, divide and emit.
module wmu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  wmu_pkg::wmu_status_t  status,
    output logic                  s_tready,
    output wmu_pkg::wmu_cmd_t     cmd
);
    import wmu_pkg::*;

    wmu_state_t state_reg;
    wmu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (status.op == OP_SCALE)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    // Take the next element while this one is summed
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DECIDE:
            begin
                cmd.decide_en = 1'b1;
                state_next    = status.dec_upd ? ST_SCORE_START : ST_EMIT;
            end
            ST_SCORE_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_SCORE_RUN;
            end
            ST_SCORE_RUN:
            begin
                if (status.div_done)
                begin
                    cmd.score_ld     = 1'b1;
                    cmd.div_start    = 1'b1;
                    cmd.div_sel_step = 1'b1;
                    state_next       = ST_STEP_RUN;
                end
            end
            ST_STEP_RUN:
            begin
                if (status.div_done)
                begin
                    cmd.step_ld = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> status.out_free)
        else $error("output register overwritten");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_step_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_ld |=> state_reg == ST_EMIT)
        else $error("step load not followed by emit");
`endif

endmodule

FILE: hdl/window_margin_update.sv
// Top level of the window margin update block: controller and datapath.
// Accumulate elements pass through the multiply stage then the saturating accumulate; the next
// element is taken in the accumulate cycle when offered, else the controller first returns to idle.
// Last element, no violation: decide, then emit. With a violation, score and step are
// computed by two bit-serial divisions in turn on one divider before the emit.
// Scale element: multiply, then scale and emit; the next item is taken back in idle.
// Reset clears the state machine, accumulator, stored step/direction/update and output valid.
module window_margin_update #(
    parameter int FRAC_BITS = wmu_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // alpha_value[31:0], kernel_value[63:32], kprime_value[95:64],
    // sigma_value[127:96], norm_value[158:128], zero [159]
    input  logic [wmu_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tuser,   // op
    input  logic                          s_axis_tlast,   // is_last
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // update_needed[0], direction[1], step[33:2], score[65:34],
    // scaled[97:66], zero [103:98]
    output logic [wmu_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tuser    // kind
);
    import wmu_pkg::*;

    wmu_cmd_t    cmd;
    wmu_status_t status;

    wmu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .status   (status),
        .s_tready (s_axis_tready),
        .cmd      (cmd)
    );

    wmu_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .s_tlast  (s_axis_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

endmodule
